// ===== rtl/core/swlrl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding-window-log rate limiter package
// Field widths, default sizes, operation and status codes.
// ----------------------------------------------------------------------------
package swlrl_pkg;

  localparam int unsigned CLIENT_W = 4;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned TIME_W   = 32;

  localparam int unsigned NUM_CLIENTS_DEF = 16;
  localparam int unsigned MAX_DEPTH_DEF   = 64;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_REQUEST  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_UNREG = 2'd2,
    ST_BUSY  = 2'd3
  } status_e;

endpackage

// ===== rtl/core/sliding_window_log_rate_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// Sliding-window-log rate limiter
// Per-client request limiter that keeps a log of recent request time stamps.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item per transfer: op_i selects a client
//   registration or an access request for slot client_i. The output channel
//   returns one result per item (allowed_o, status_o), in order.
//   One item is in flight at a time. A registration passes through the idle,
//   slot lookup and finish states from input transfer until its result is registered.
//   A request to a registered slot adds a decide state, plus a stamp state for
//   every stamp read from the stamp memory: each expired stamp that is dropped,
//   and the live stamp that ends the scan. The slot record is read as the item is
//   taken, used in lookup and written back in decide (in lookup for a registration).
//   The next item is taken once the result sits in the output register, so
//   a waiting result does not hold up the input. If the receiver stalls with
//   a result still waiting, the following item completes its work and holds
//   in its last state until the output register is free.
//   After reset the slot table is cleared, one slot per cycle; in_ready_o
//   stays low during that pass.
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter_unit #(
  parameter int unsigned NUM_CLIENTS = swlrl_pkg::NUM_CLIENTS_DEF,
  parameter int unsigned MAX_DEPTH   = swlrl_pkg::MAX_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [swlrl_pkg::CLIENT_W-1:0] client_i,
  input  logic [swlrl_pkg::LIMIT_W-1:0]  limit_i,
  input  logic [swlrl_pkg::TIME_W-1:0]   window_i,
  input  logic [swlrl_pkg::TIME_W-1:0]   now_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          allowed_o,
  output logic [1:0]                    status_o
);
  import swlrl_pkg::*;

  localparam int unsigned CLW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int unsigned DW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned PW  = CW + 1;
  localparam int unsigned SD  = NUM_CLIENTS * MAX_DEPTH;
  localparam int unsigned AW  = (SD > 1) ? $clog2(SD) : 1;

  typedef struct packed {
    logic              used;
    logic [CW-1:0]     lim;
    logic [TIME_W-1:0] win;
    logic [DW-1:0]     head;
    logic [CW-1:0]     cnt;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT,
    S_STAMP,
    S_DECIDE,
    S_FIN
  } state_e;

  // Memories.
  slot_t             slot_mem [NUM_CLIENTS];
  logic [TIME_W-1:0] stamp_mem [SD];

  state_e            state_q, state_d;
  logic [CLW-1:0]    clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic              allowed_q, allowed_d;
  status_e           status_q, status_d;

  logic              op_q, op_d;
  logic              inrange_q, inrange_d;
  logic [CLW-1:0]    slot_q, slot_d;
  logic [CW-1:0]     lim_q, lim_d;
  logic [TIME_W-1:0] win_q, win_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [TIME_W-1:0] edge_q, edge_d;
  logic [DW-1:0]     head_q, head_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              res_ok_q, res_ok_d;
  status_e           res_st_q, res_st_d;

  logic              slot_we, slot_re;
  logic [CLW-1:0]    slot_waddr, slot_raddr;
  slot_t             slot_wdata, slot_rd_q;
  logic              stamp_we, stamp_re;
  logic [AW-1:0]     stamp_waddr, stamp_raddr;
  logic [TIME_W-1:0] stamp_rd_q;

  logic [31:0]       client_ext;
  logic [CLW-1:0]    client_idx;
  logic              client_ok;
  logic [CW-1:0]     lim_clamped;
  logic [AW-1:0]     base;
  logic [DW-1:0]     head_inc;
  logic [PW-1:0]     pos_sum;
  logic [DW-1:0]     pos;

  assign client_ext  = 32'(client_i);
  assign client_idx  = client_ext[CLW-1:0];
  assign client_ok   = client_ext < 32'(NUM_CLIENTS);
  assign lim_clamped = (32'(limit_i) > 32'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(limit_i);

  // Each slot owns MAX_DEPTH consecutive stamp entries.
  assign base     = AW'(slot_q) * AW'(MAX_DEPTH);
  assign head_inc = (32'(head_q) + 32'd1 == 32'(MAX_DEPTH)) ? '0 : DW'(head_q + 1'b1);
  assign pos_sum  = PW'(head_q) + PW'(cnt_q);
  assign pos      = (pos_sum >= PW'(MAX_DEPTH)) ? DW'(pos_sum - PW'(MAX_DEPTH))
                                                : DW'(pos_sum);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign allowed_o   = allowed_q;
  assign status_o    = status_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    allowed_d   = allowed_q;
    status_d    = status_q;
    op_d        = op_q;
    inrange_d   = inrange_q;
    slot_d      = slot_q;
    lim_d       = lim_q;
    win_d       = win_q;
    now_d       = now_q;
    edge_d      = edge_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    res_ok_d    = res_ok_q;
    res_st_d    = res_st_q;
    slot_we     = 1'b0;
    slot_waddr  = slot_q;
    slot_wdata  = '{used: 1'b1, lim: lim_q, win: win_q, head: head_q, cnt: cnt_q};
    slot_re     = 1'b0;
    slot_raddr  = client_idx;
    stamp_we    = 1'b0;
    stamp_waddr = base + AW'(pos);
    stamp_re    = 1'b0;
    stamp_raddr = base + AW'(head_q);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + 1'b1;
        if (32'(clr_q) == 32'(NUM_CLIENTS) - 32'd1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_i;
          inrange_d = client_ok;
          slot_d    = client_idx;
          lim_d     = lim_clamped;
          win_d     = window_i;
          now_d     = now_i;
          slot_re   = 1'b1;
          state_d   = S_SLOT;
        end
      end
      S_SLOT: begin
        state_d = S_FIN;
        if (!inrange_q) begin
          res_ok_d = 1'b0;
          res_st_d = ST_UNREG;
        end else if (op_q == OP_REGISTER) begin
          if (slot_rd_q.used) begin
            res_ok_d = 1'b0;
            res_st_d = ST_DUP;
          end else begin
            slot_we    = 1'b1;
            slot_wdata = '{used: 1'b1, lim: lim_q, win: win_q, head: '0, cnt: '0};
            res_ok_d   = 1'b1;
            res_st_d   = ST_OK;
          end
        end else if (!slot_rd_q.used) begin
          res_ok_d = 1'b0;
          res_st_d = ST_UNREG;
        end else begin
          lim_d  = slot_rd_q.lim;
          win_d  = slot_rd_q.win;
          head_d = slot_rd_q.head;
          cnt_d  = slot_rd_q.cnt;
          edge_d = now_q - slot_rd_q.win;
          // Nothing can expire while the window still reaches back past zero.
          if ((slot_rd_q.win <= now_q) && (slot_rd_q.cnt != '0)) begin
            stamp_re    = 1'b1;
            stamp_raddr = base + AW'(slot_rd_q.head);
            state_d     = S_STAMP;
          end else begin
            state_d = S_DECIDE;
          end
        end
      end
      S_STAMP: begin
        if (stamp_rd_q <= edge_q) begin
          head_d = head_inc;
          cnt_d  = cnt_q - 1'b1;
          if (cnt_q > CW'(1)) begin
            stamp_re    = 1'b1;
            stamp_raddr = base + AW'(head_inc);
          end else begin
            state_d = S_DECIDE;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        slot_we = 1'b1;
        state_d = S_FIN;
        if (cnt_q < lim_q) begin
          stamp_we   = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          slot_wdata = '{used: 1'b1, lim: lim_q, win: win_q, head: head_q,
                         cnt: CW'(cnt_q + 1'b1)};
          res_ok_d   = 1'b1;
          res_st_d   = ST_OK;
        end else begin
          res_ok_d = 1'b0;
          res_st_d = ST_BUSY;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          allowed_d   = res_ok_q;
          status_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      allowed_q   <= 1'b0;
      status_q    <= ST_OK;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      allowed_q   <= allowed_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    inrange_q <= inrange_d;
    slot_q    <= slot_d;
    lim_q     <= lim_d;
    win_q     <= win_d;
    now_q     <= now_d;
    edge_q    <= edge_d;
    head_q    <= head_d;
    cnt_q     <= cnt_d;
    res_ok_q  <= res_ok_d;
    res_st_q  <= res_st_d;
  end

  // Slot table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_re) begin
      slot_rd_q <= slot_mem[slot_raddr];
    end
  end

  // Stamp log: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[stamp_waddr] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stamp_re) begin
      stamp_rd_q <= stamp_mem[stamp_raddr];
    end
  end

  // A slot's log never holds more stamps than its limit allows.
  a_cnt_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> (cnt_q <= lim_q))
    else $error("stamp count exceeds slot limit");

  // The stamp memory is only scanned while the log is non-empty.
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STAMP) |-> (cnt_q != '0))
    else $error("stamp scan on an empty log");

  // A result appears only after the item has finished its work.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result presented outside the finish state");

  // An accepted item moves straight on to the slot lookup.
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SLOT))
    else $error("accepted item did not start its slot lookup");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Rate limiter unit testbench
// Drives client registrations and access requests into the limiter with
// bursty input traffic and a stalling receiver. A scoreboard keeps its own
// copy of the slot table and time stamp rings, works out the verdict for
// every transfer, and compares each returned result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import swlrl_pkg::*;

  localparam int unsigned NUM_SLOTS    = NUM_CLIENTS_DEF;
  localparam int unsigned RING_DEPTH   = MAX_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned SETTLE_CYC   = 100;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic    allowed;
    status_e status;
  } verdict_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_e;

  class rate_limit_scoreboard;
    bit                  slot_used   [NUM_SLOTS];
    logic [LIMIT_W-1:0]  slot_limit  [NUM_SLOTS];
    logic [TIME_W-1:0]   slot_window [NUM_SLOTS];
    logic [5:0]          ring_head   [NUM_SLOTS];
    logic [6:0]          ring_count  [NUM_SLOTS];
    logic [TIME_W-1:0]   stamp_store [NUM_SLOTS*RING_DEPTH];
    verdict_t            due_verdicts[$];
    int                  failures;
    int                  results_seen;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]   = 1'b0;
        slot_limit[i]  = '0;
        slot_window[i] = '0;
        ring_head[i]   = '0;
        ring_count[i]  = '0;
      end
      foreach (stamp_store[i]) stamp_store[i] = '0;
      failures     = 0;
      results_seen = 0;
    endfunction

    // Works out the verdict for one accepted transfer and updates the slot
    // table and stamp rings the way the limiter should.
    function void rule_on_transfer(logic op, logic [CLIENT_W-1:0] client,
                                   logic [LIMIT_W-1:0] limit,
                                   logic [TIME_W-1:0] window,
                                   logic [TIME_W-1:0] stamp);
      verdict_t          v;
      int unsigned       base;
      logic [TIME_W-1:0] cutoff;
      base = client * RING_DEPTH;
      v.allowed = 1'b0;
      v.status  = ST_OK;
      if (op == OP_REGISTER) begin
        if (slot_used[client]) begin
          v.status = ST_DUP;
        end else begin
          slot_used[client]   = 1'b1;
          slot_limit[client]  = (limit > RING_DEPTH) ? LIMIT_W'(RING_DEPTH) : limit;
          slot_window[client] = window;
          ring_head[client]   = '0;
          ring_count[client]  = '0;
          v.allowed = 1'b1;
        end
      end else if (!slot_used[client]) begin
        v.status = ST_UNREG;
      end else begin
        // Expiry never wraps: with a window longer than now nothing expires.
        if (slot_window[client] <= stamp) begin
          cutoff = stamp - slot_window[client];
          while (ring_count[client] != 0 &&
                 stamp_store[base + ring_head[client]] <= cutoff) begin
            ring_head[client]  = 6'((ring_head[client] + 1) % RING_DEPTH);
            ring_count[client] = ring_count[client] - 7'd1;
          end
        end
        if (ring_count[client] < slot_limit[client]) begin
          stamp_store[base + (ring_head[client] + ring_count[client]) % RING_DEPTH] = stamp;
          ring_count[client] = ring_count[client] + 7'd1;
          v.allowed = 1'b1;
        end else begin
          v.status = ST_BUSY;
        end
      end
      due_verdicts.push_back(v);
    endfunction

    function void report(string what);
      failures++;
      if (failures <= 10) $display("ERROR: %s", what);
    endfunction

    function void check_verdict(logic allowed, logic [1:0] status);
      verdict_t exp_v;
      results_seen++;
      if (due_verdicts.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending (allowed=%0b status=%0d)",
                         results_seen, allowed, status));
      end else begin
        exp_v = due_verdicts.pop_front();
        if (allowed !== exp_v.allowed || status !== exp_v.status)
          report($sformatf("result %0d: expected allowed=%0b status=%0d, got allowed=%0b status=%0d",
                           results_seen, exp_v.allowed, exp_v.status, allowed, status));
      end
    endfunction

    function void close_out();
      if (due_verdicts.size() != 0)
        report($sformatf("%0d results never arrived", due_verdicts.size()));
    endfunction

    function int pending();
      return due_verdicts.size();
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_op     = OP_REGISTER;
  logic [CLIENT_W-1:0] in_client = '0;
  logic [LIMIT_W-1:0]  in_limit  = '0;
  logic [TIME_W-1:0]   in_window = '0;
  logic [TIME_W-1:0]   in_now    = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic                out_allowed;
  logic [1:0]          out_status;

  rate_limit_scoreboard sb;
  int       burst_left  = 0;
  int       cycle_count = 0;
  int       rx_left     = 0;
  rx_mode_e rx_mode     = RX_OPEN;

  sliding_window_log_rate_limiter_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (in_op),
    .client_i    (in_client),
    .limit_i     (in_limit),
    .window_i    (in_window),
    .now_i       (in_now),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .allowed_o   (out_allowed),
    .status_o    (out_status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // The receiver switches between open, coin-flip, sparse and pulsed stalls.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(8, 120);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
      default:   out_ready <= rx_left[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_verdict(out_allowed, out_status);
  end

  // To be called just after the clock rises. Returns once the item is taken,
  // with valid still high so that a following item can go out without valid dropping.
  task automatic send_item(logic op, logic [CLIENT_W-1:0] client,
                           logic [LIMIT_W-1:0] limit, logic [TIME_W-1:0] window,
                           logic [TIME_W-1:0] stamp);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 15);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_op     <= op;
    in_client <= client;
    in_limit  <= limit;
    in_window <= window;
    in_now    <= stamp;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.rule_on_transfer(op, client, limit, window, stamp);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic                op_r;
    logic [CLIENT_W-1:0] cl;
    logic [LIMIT_W-1:0]  lim;
    logic [TIME_W-1:0]   win;
    logic [TIME_W-1:0]   stamp;
    logic [TIME_W-1:0]   base;
    logic [CLIENT_W-1:0] hot;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Unregistered slot, then a slot with a zero limit and a repeat registration.
    send_item(OP_REQUEST,  4'd5, 7'($urandom), $urandom, 32'd100);
    send_item(OP_REGISTER, 4'd0, 7'd0, 32'd50, $urandom);
    send_item(OP_REQUEST,  4'd0, 7'($urandom), $urandom, 32'd10);
    send_item(OP_REGISTER, 4'd0, 7'd5, 32'd1, $urandom);
    // Limit of two in a window of ten, with time going backwards at the end.
    // The last request is refused because only the front stamp is examined.
    send_item(OP_REGISTER, 4'd1, 7'd2, 32'd10, $urandom);
    send_item(OP_REQUEST,  4'd1, 7'($urandom), $urandom, 32'd0);
    send_item(OP_REQUEST,  4'd1, 7'($urandom), $urandom, 32'd1);
    send_item(OP_REQUEST,  4'd1, 7'($urandom), $urandom, 32'd2);
    send_item(OP_REQUEST,  4'd1, 7'($urandom), $urandom, 32'd11);
    send_item(OP_REQUEST,  4'd1, 7'($urandom), $urandom, 32'd3);
    send_item(OP_REQUEST,  4'd1, 7'($urandom), $urandom, 32'd14);
    // Widest window against the largest time stamp.
    send_item(OP_REGISTER, 4'd2, 7'd1, 32'hFFFF_FFFF, $urandom);
    send_item(OP_REQUEST,  4'd2, 7'($urandom), $urandom, 32'd5);
    send_item(OP_REQUEST,  4'd2, 7'($urandom), $urandom, 32'hFFFF_FFFF);
    // Zero window with an oversized limit that is clamped to the ring depth.
    send_item(OP_REGISTER, 4'd3, 7'd127, 32'd0, 32'd0);
    send_item(OP_REQUEST,  4'd3, 7'd0, 32'd0, 32'd0);
    send_item(OP_REQUEST,  4'd3, 7'd127, 32'hFFFF_FFFF, 32'd0);
    send_item(OP_REQUEST,  4'd3, 7'($urandom), $urandom, 32'hFFFF_FFFF);
    send_item(OP_REGISTER, 4'd15, 7'd64, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_REQUEST,  4'd15, 7'($urandom), $urandom, 32'h7FFF_FFFF);
    send_item(OP_REQUEST,  4'd15, 7'($urandom), $urandom, 32'h8000_0000);
    send_item(OP_REGISTER, 4'd4, 7'd65, 32'd100, $urandom);
    send_item(OP_REQUEST,  4'd15, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_results();

    // Requests mostly follow a slowly advancing clock and favor one hot slot
    // at a time, so rings fill, expire and wrap.
    base = 32'd1000;
    hot  = 4'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_results();
      if ($urandom_range(0, 79) == 0) hot = 4'($urandom);
      if ($urandom_range(0, 32) == 0) base = $urandom;
      else base = base + $urandom_range(0, 6);
      stamp = ($urandom_range(0, 11) == 0) ? $urandom : base;
      lim   = 7'($urandom);
      win   = $urandom;
      if ($urandom_range(0, 24) == 0) begin
        op_r = OP_REGISTER;
        cl   = 4'($urandom);
        case ($urandom_range(0, 4))
          0:       lim = 7'd0;
          1:       lim = 7'($urandom_range(1, 8));
          2:       lim = 7'($urandom_range(60, 64));
          3:       lim = 7'($urandom_range(65, 127));
          default: lim = 7'($urandom);
        endcase
        case ($urandom_range(0, 4))
          0:       win = '0;
          1:       win = $urandom_range(1, 40);
          2:       win = $urandom_range(40, 400);
          3:       win = 32'hFFFF_FFFF;
          default: win = $urandom;
        endcase
      end else begin
        op_r = OP_REQUEST;
        cl   = ($urandom_range(0, 9) < 6) ? hot : 4'($urandom);
      end
      send_item(op_r, cl, lim, win, stamp);
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sliding_window_log_rate_limiter_unit.f =====
rtl/core/swlrl_pkg.sv
rtl/core/sliding_window_log_rate_limiter_unit.sv
bench/tb_top.sv
